// ----- sv/pmdd_pkg.sv -----
// Shared types and constants for the peak meter with dB decay.
`timescale 1ns / 1ps
package pmdd_pkg;

   localparam int          LEVEL_W     = 17;
   localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = -17'sd49152;
   localparam logic [26:0] DB_LOG2_K   = 27'd101008905;
   localparam logic [4:0]  DECAY_DEN   = 5'd17;
   localparam logic [16:0] DECAY_MAX   = 17'd65536;

   localparam int CFG_RATE    = 0;
   localparam int CFG_GLOBAL  = 1;
   localparam int CFG_CHANS   = 2;

   typedef enum logic {
      FUNC_PEAK = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CH_LOAD,
      ST_LOG,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_MERGE,
      ST_EMIT_GLB,
      ST_EMIT_CH
   } back_state_type;

endpackage

// ----- sv/pmdd_front.sv -----
// Front part: accumulates peak reports, snapshots them into a tick command.
`timescale 1ns / 1ps
module pmdd_front
   import pmdd_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [3:0]                  req_channel,
   input  logic [15:0]                 req_peak,
   input  logic [15:0]                 req_samples_added,
   input  logic [4:0]                  active_n,
   // tick queue write side
   output logic                        tq_push,
   output logic [31:0]                 tq_samples,
   output logic [CHANNELS*16-1:0]      tq_holds,
   input  logic                        tq_full
);

   logic [15:0] hold_ff [CHANNELS];
   logic [15:0] hold_in [CHANNELS];
   logic [31:0] count_ff, count_in;
   logic [32:0] sum;
   logic        acc;

   // ticks wait for queue space, peaks never stall
   assign req_ready = !(req_func == FUNC_TICK && tq_full);
   assign acc       = req_valid && req_ready;
   assign sum       = {1'b0, count_ff} + {17'd0, req_samples_added};

   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < CHANNELS; i++) hold_in[i] = hold_ff[i];
      if (acc) begin
         if (req_func == FUNC_TICK) begin
            count_in = '0;
            for (int i = 0; i < CHANNELS; i++) hold_in[i] = '0;
         end else begin
            count_in = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            for (int i = 0; i < CHANNELS; i++) begin
               if (req_channel == 4'(i) && {1'b0, req_channel} < active_n
                   && req_peak > hold_ff[i])
                  hold_in[i] = req_peak;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) hold_ff[i] <= '0;
      end else begin
         count_ff <= count_in;
         for (int i = 0; i < CHANNELS; i++) hold_ff[i] <= hold_in[i];
      end
   end

   assign tq_push    = acc && req_func == FUNC_TICK;
   assign tq_samples = count_ff;
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) tq_holds[i*16 +: 16] = hold_ff[i];
   end

endmodule

// ----- sv/pmdd_queue.sv -----
// Two-entry queue of tick commands between front and back.
`timescale 1ns / 1ps
module pmdd_queue #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign head      = data_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) data_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ----- sv/pmdd_back.sv -----
// Back part: decay divide, log conversion, level update and result emission.
`timescale 1ns / 1ps
module pmdd_back
   import pmdd_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic [31:0]                 q_samples,
   input  logic [CHANNELS*16-1:0]      q_holds,
   input  logic [17:0]                 sample_rate,
   input  logic                        global_enable,
   input  logic [4:0]                  active_n,
   input  logic                        csr_chans_wr,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_kind,
   output logic [3:0]                  rsp_channel_res,
   output logic signed [16:0]          rsp_level_db,
   output logic                        rsp_last
);

   localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   back_state_type state_ff, state_in;

   logic signed [16:0] lvl_ff [CHANNELS];
   logic [15:0]        hold_ff [CHANNELS];
   logic [CW-1:0]      ch_ff;
   logic [5:0]         step_ff;
   // restoring divider: numerator 48 bits, divisor 23 bits
   logic [47:0]        quo_ff;
   logic [23:0]        rem_ff;
   logic [22:0]        den_ff;
   logic [16:0]        decay_ff;
   // log unit
   logic [31:0]        man_ff;
   logic [15:0]        frac_ff;
   logic signed [4:0]  expo_ff;
   logic signed [21:0] lq_ff;
   logic signed [63:0] prod_ff;
   logic signed [16:0] max_ff;
   logic signed [16:0] pdb;
   logic signed [49:0] mul;

   // valid flag of the result output register
   logic               out_ff_valid;

   logic [23:0]        rem_sh;
   logic [63:0]        sq;
   logic [3:0]         hb;
   logic [15:0]        cur_hold;

   assign cur_hold = hold_ff[ch_ff];
   assign rem_sh   = {rem_ff[22:0], quo_ff[47]};
   assign sq       = {32'd0, man_ff} * {32'd0, man_ff};
   assign mul      = lq_ff * $signed({1'b0, DB_LOG2_K});

   always_comb begin
      hb = '0;
      for (int b = 0; b < 16; b++) if (cur_hold[b]) hb = 4'(b);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (q_valid) state_in = (sample_rate == '0) ? ST_IDLE : ST_DIV;
         ST_DIV:
            if (step_ff == 6'd47) state_in = ST_CH_LOAD;
         ST_CH_LOAD:
            state_in = (cur_hold == '0) ? ST_MERGE : ST_LOG;
         ST_LOG:
            if (step_ff == 6'd15) state_in = ST_MUL_LO;
         ST_MUL_LO:
            state_in = ST_MUL_HI;
         ST_MUL_HI:
            state_in = ST_MERGE;
         ST_MERGE:
            if ({1'b0, ch_ff} + 1 >= active_n)
               state_in = global_enable ? ST_EMIT_GLB : ST_EMIT_CH;
            else
               state_in = ST_CH_LOAD;
         ST_EMIT_GLB:
            if (!out_ff_valid || rsp_ready) state_in = ST_EMIT_CH;
         ST_EMIT_CH:
            if ((!out_ff_valid || rsp_ready) && {1'b0, ch_ff} + 1 >= active_n)
               state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign q_pop = state_ff == ST_IDLE && q_valid;

   // dB of the log value with rounding
   always_comb begin
      pdb = 17'(prod_ff[63:32]);
   end

   // merged level of the current channel
   function automatic logic signed [16:0] lvl_in_merge();
      logic signed [18:0] t;
      t = 19'(lvl_ff[ch_ff]) - 19'($signed({1'b0, decay_ff}));
      if (cur_hold != '0 && 19'(pdb) > t) t = 19'(pdb);
      if (t < 19'(LEVEL_FLOOR)) t = 19'(LEVEL_FLOOR);
      return 17'(t);
   endfunction

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            // samples * 51200, with 51200 = 25 * 2^11
            quo_ff  <= ({16'd0, q_samples} << 15) + ({16'd0, q_samples} << 14)
                       + ({16'd0, q_samples} << 11);
            rem_ff  <= '0;
            den_ff  <= 23'(sample_rate) * 23'(DECAY_DEN);
            step_ff <= '0;
            ch_ff   <= '0;
            for (int i = 0; i < CHANNELS; i++) hold_ff[i] <= q_holds[i*16 +: 16];
         end
         ST_DIV: begin
            step_ff <= step_ff + 6'd1;
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_ff <= rem_sh - {1'b0, den_ff};
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
            if (step_ff == 6'd47) begin
               step_ff <= '0;
            end
         end
         ST_CH_LOAD: begin
            man_ff  <= 32'(cur_hold) << (5'd30 - 5'(hb));
            expo_ff <= 5'(hb) - 5'sd15;
            frac_ff <= '0;
            step_ff <= '0;
         end
         ST_LOG: begin
            step_ff <= step_ff + 6'd1;
            if (sq[61]) begin
               man_ff  <= sq[62:31];
               frac_ff <= {frac_ff[14:0], 1'b1};
            end else begin
               man_ff  <= sq[61:30];
               frac_ff <= {frac_ff[14:0], 1'b0};
            end
         end
         ST_MUL_LO: begin
            lq_ff <= {expo_ff[4], expo_ff, 16'd0} + {6'd0, frac_ff};
         end
         ST_MUL_HI: begin
            prod_ff <= 64'(mul) + 64'sd2147483648;
         end
         ST_MERGE: begin
            if (ch_ff == '0 || lvl_in_merge() > max_ff) max_ff <= lvl_in_merge();
            if ({1'b0, ch_ff} + 1 >= active_n) ch_ff <= '0;
            else ch_ff <= ch_ff + 1'b1;
         end
         ST_EMIT_CH:
            if (!out_ff_valid || rsp_ready) ch_ff <= ch_ff + 1'b1;
         default: ;
      endcase
      if (state_ff == ST_DIV && step_ff == 6'd47)
         decay_ff <= (quo_ff[46:0] > 47'(DECAY_MAX) >> 1 || rem_sh >= {1'b0, den_ff}
                      && 48'({quo_ff[46:0], 1'b1}) > 48'(DECAY_MAX))
                     ? DECAY_MAX
                     : ((48'({quo_ff[46:0], rem_sh >= {1'b0, den_ff}}) > 48'(DECAY_MAX))
                        ? DECAY_MAX
                        : 17'({quo_ff[46:0], rem_sh >= {1'b0, den_ff}}));
   end

   // level store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) lvl_ff[i] <= LEVEL_FLOOR;
      end else if (csr_chans_wr) begin
         for (int i = 0; i < CHANNELS; i++)
            if (5'(i) >= active_n) lvl_ff[i] <= LEVEL_FLOOR;
      end else if (state_ff == ST_MERGE) begin
         lvl_ff[ch_ff] <= lvl_in_merge();
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff_valid <= 1'b0;
      end else if (!out_ff_valid || rsp_ready) begin
         out_ff_valid <= state_ff == ST_EMIT_GLB || state_ff == ST_EMIT_CH;
         if (state_ff == ST_EMIT_GLB) begin
            rsp_kind        <= 1'b1;
            rsp_channel_res <= '0;
            rsp_level_db    <= max_ff;
            rsp_last        <= 1'b0;
         end else begin
            rsp_kind        <= 1'b0;
            rsp_channel_res <= 4'(ch_ff);
            rsp_level_db    <= lvl_ff[ch_ff];
            rsp_last        <= {1'b0, ch_ff} + 1 >= active_n;
         end
      end
   end

   assign rsp_valid = out_ff_valid;

endmodule

// ----- sv/peak_meter_db_decay_top.sv -----
// Top level of the multichannel peak meter with dB decay.
// Usage:
//   Requests enter on req_* (valid/ready). func 0 is a peak report: it is
//   taken every cycle and updates the per-channel hold and sample counter.
//   func 1 is a tick: it is queued (two deep) to the back end, which divides
//   the counted samples for the decay (one quotient bit a cycle), then per
//   channel runs a 16-step squaring log2 and a multiply (ST_MUL_LO, ST_MUL_HI).
//   A channel with a zero hold skips the log and the multiply. A tick with
//   sample_rate 0 is dropped and yields no results.
//   Results leave on rsp_* (valid/ready) from one output register, global
//   maximum first when enabled, then one per active channel, last on the
//   final one. A stalled receiver holds the back end; peak reports keep
//   flowing and only a third waiting tick stalls req_ready.
//   Configuration writes via csr_* take effect at once; a channel count
//   write floors the levels of channels above the count.
//   Reset: sample_rate 48000, global off, 2 channels, levels at -192 dB.
`timescale 1ns / 1ps
module peak_meter_db_decay_top
   import pmdd_pkg::*;
#(
   parameter int CHANNELS = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [3:0]          req_channel,
   input  logic [15:0]         req_peak,
   input  logic [15:0]         req_samples_added,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_kind,
   output logic [3:0]          rsp_channel_res,
   output logic signed [16:0]  rsp_level_db,
   output logic                rsp_last,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [17:0]         csr_wdata
);

   localparam int QW = 32 + CHANNELS * 16;

   logic [17:0] rate_ff;
   logic        glb_ff;
   logic [4:0]  chans_ff;
   logic [4:0]  active_n;
   logic [4:0]  new_n;
   logic        chans_wr;

   logic                   tq_push, tq_full, q_valid, q_pop;
   logic [31:0]            tq_samples;
   logic [CHANNELS*16-1:0] tq_holds;
   logic [QW-1:0]          q_head;

   // active count clamped to 1..CHANNELS
   function automatic logic [4:0] clamp_n(input logic [4:0] v);
      if (v == 5'd0) return 5'd1;
      if (v > 5'(CHANNELS)) return 5'(CHANNELS);
      return v;
   endfunction

   assign active_n = clamp_n(chans_ff);
   assign chans_wr = csr_we && csr_index == 2'(CFG_CHANS);
   assign new_n    = clamp_n(csr_wdata[4:0]);

   function automatic logic [4:0] new_n_sel();
      return chans_wr ? new_n : active_n;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= 18'd48000;
         glb_ff   <= 1'b0;
         chans_ff <= 5'd2;
      end else if (csr_we) begin
         if (csr_index == 2'(CFG_RATE))   rate_ff  <= csr_wdata;
         if (csr_index == 2'(CFG_GLOBAL)) glb_ff   <= csr_wdata[0];
         if (csr_index == 2'(CFG_CHANS))  chans_ff <= csr_wdata[4:0];
      end
   end

   pmdd_front #(.CHANNELS(CHANNELS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_channel,
      .req_peak, .req_samples_added, .active_n,
      .tq_push, .tq_samples, .tq_holds, .tq_full
   );

   pmdd_queue #(.WIDTH(QW)) u_queue (
      .clock, .reset, .push(tq_push), .push_data({tq_samples, tq_holds}),
      .full(tq_full), .pop(q_pop), .not_empty(q_valid), .head(q_head)
   );

   pmdd_back #(.CHANNELS(CHANNELS)) u_back (
      .clock, .reset, .q_valid, .q_pop,
      .q_samples(q_head[QW-1 -: 32]), .q_holds(q_head[CHANNELS*16-1:0]),
      .sample_rate(rate_ff), .global_enable(glb_ff), .active_n(new_n_sel()),
      .csr_chans_wr(chans_wr),
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_channel_res, .rsp_level_db, .rsp_last
   );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the peak meter with dB decay.
`timescale 1ns / 1ps
module tb;
   import pmdd_pkg::*;

   localparam int NCH      = 2;
   localparam int WD_LIMIT = 6000;
   localparam int SETTLE   = 250;

   typedef struct {
      logic               kind;
      logic [3:0]         ch;
      logic signed [16:0] level;
      logic               last;
   } level_rsp_type;

   // Level predictor plus expected-result queue.
   class level_scoreboard_type;
      level_rsp_type pending[$];
      int          errors;
      logic [17:0] rate;
      logic        glb_en;
      logic [4:0]  chans;
      logic [15:0] hold[NCH];
      int          level[NCH];
      logic [31:0] counter;

      function new();
         rate    = 18'd48000;
         glb_en  = 1'b0;
         chans   = 5'd2;
         counter = '0;
         errors  = 0;
         for (int i = 0; i < NCH; i++) begin
            hold[i]  = '0;
            level[i] = LEVEL_FLOOR;
         end
      endfunction

      function int active();
         int n;
         n = chans;
         if (n < 1) n = 1;
         if (n > NCH) n = NCH;
         return n;
      endfunction

      // Q8.8 dB of a nonzero Q1.15 peak, log2 by repeated squaring.
      function int peak_db(logic [15:0] p);
         int                 e;
         logic [63:0]        m;
         longint             frac;
         longint             l;
         longint             prod;
         e    = 15;
         frac = 0;
         while (e > 0 && p[e] == 1'b0) e--;
         m = 64'(p) << (30 - e);
         for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               frac = frac | (longint'(1) << i);
            end
         end
         l    = longint'(e - 15) * 65536 + frac;
         prod = l * longint'(DB_LOG2_K) + 64'sd2147483648;
         return int'(prod >>> 32);
      endfunction

      function void write_reg(int idx, logic [17:0] val);
         case (idx)
            CFG_RATE:   rate = val;
            CFG_GLOBAL: glb_en = val[0];
            CFG_CHANS: begin
               chans = val[4:0];
               for (int i = active(); i < NCH; i++) level[i] = LEVEL_FLOOR;
            end
            default: ;
         endcase
      endfunction

      // Accepted request: update state and queue the levels it yields.
      function void note_request(func_type f, logic [3:0] ch, logic [15:0] pk,
                                 logic [15:0] add);
         int            n;
         logic [31:0]   samples;
         longint        decay;
         longint        lvl;
         int            maxlvl;
         level_rsp_type r;
         n = active();
         if (f == FUNC_PEAK) begin
            if (counter > 32'hFFFF_FFFF - add) counter = 32'hFFFF_FFFF;
            else counter = counter + add;
            if (ch < n && pk > hold[ch]) hold[ch] = pk;
            return;
         end
         samples = counter;
         counter = '0;
         if (rate == 0) begin
            for (int i = 0; i < NCH; i++) hold[i] = '0;
            return;
         end
         decay = longint'((64'(samples) * 64'd51200) / (64'(rate) * 64'd17));
         if (decay > 65536) decay = 65536;
         maxlvl = LEVEL_FLOOR;
         for (int i = 0; i < n; i++) begin
            lvl = longint'(level[i]) - decay;
            if (hold[i] != 0 && longint'(peak_db(hold[i])) > lvl)
               lvl = peak_db(hold[i]);
            if (lvl < LEVEL_FLOOR) lvl = LEVEL_FLOOR;
            level[i] = int'(lvl);
            if (i == 0 || level[i] > maxlvl) maxlvl = level[i];
         end
         for (int i = 0; i < NCH; i++) hold[i] = '0;
         if (glb_en) begin
            r.kind = 1'b1; r.ch = '0; r.level = 17'(maxlvl); r.last = 1'b0;
            pending.push_back(r);
         end
         for (int i = 0; i < n; i++) begin
            r.kind = 1'b0; r.ch = 4'(i); r.level = 17'(level[i]);
            r.last = (i + 1 == n);
            pending.push_back(r);
         end
      endfunction

      function void check_result(level_rsp_type got);
         level_rsp_type exp_r;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected level: kind %0d ch %0d level %0d last %0d",
                        got.kind, got.ch, got.level, got.last);
            return;
         end
         exp_r = pending.pop_front();
         if (got.kind !== exp_r.kind || got.ch !== exp_r.ch ||
             got.level !== exp_r.level || got.last !== exp_r.last) begin
            errors++;
            if (errors <= 10)
               $display("level mismatch kind/ch/level/last: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        exp_r.kind, exp_r.ch, exp_r.level, exp_r.last,
                        got.kind, got.ch, got.level, got.last);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_func;
   logic [3:0]         req_channel;
   logic [15:0]        req_peak;
   logic [15:0]        req_samples_added;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_kind;
   logic [3:0]         rsp_channel_res;
   logic signed [16:0] rsp_level_db;
   logic               rsp_last;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [17:0]        csr_wdata;

   level_scoreboard_type meter_sb;
   int send_idle_pct;
   int recv_idle_pct;
   int quiet_cycles;

   peak_meter_db_decay_top #(.CHANNELS(NCH)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: check accepted levels, random backpressure.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         meter_sb.check_result('{rsp_kind, rsp_channel_res, rsp_level_db, rsp_last});
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("watchdog expired");
         $display("tb NOT OK");
         $finish;
      end
   end

   // Drive one request; valid stays high across back-to-back requests.
   task automatic send_request(func_type f, logic [3:0] ch, logic [15:0] pk,
                               logic [15:0] add);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= f;
      req_channel       <= ch;
      req_peak          <= pk;
      req_samples_added <= add;
      do @(posedge clock); while (!req_ready);
      meter_sb.note_request(f, ch, pk, add);
   endtask

   // Stop sending, drain all expected levels, then let the back end settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (meter_sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(int idx, logic [17:0] val);
      csr_we    <= 1'b1;
      csr_index <= 2'(idx);
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      meter_sb.write_reg(idx, val);
   endtask

   function automatic logic [15:0] rand_peak();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom) >> $urandom_range(15);
         2: return 16'($urandom_range(32760, 32775));
         default: return 16'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [15:0] rand_samples();
      case ($urandom_range(2))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 512));
         default: return 16'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [17:0] rand_rate();
      case ($urandom_range(7))
         0: return 18'd0;
         1: return 18'd1;
         2: return 18'h3FFFF;
         3: return 18'd192000;
         4: return 18'd48000;
         default: return 18'($urandom);
      endcase
   endfunction

   initial begin
      meter_sb          = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_PEAK;
      req_channel       = '0;
      req_peak          = '0;
      req_samples_added = '0;
      rsp_ready         = 1'b0;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      quiet_cycles      = 0;
      send_idle_pct     = 14;
      recv_idle_pct     = 49;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, silence, out-of-range channel.
      send_request(FUNC_PEAK, 4'd0, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_PEAK, 4'd1, 16'd1, 16'd0);
      send_request(FUNC_TICK, 4'hF, 16'hFFFF, 16'hFFFF);
      send_request(FUNC_PEAK, 4'd0, 16'd32768, 16'd100);
      send_request(FUNC_PEAK, 4'd15, 16'hFFFF, 16'd48000);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      send_request(FUNC_PEAK, 4'd1, 16'd0, 16'd1);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      drain();
      write_csr(CFG_GLOBAL, 18'd1);
      write_csr(CFG_CHANS, 18'd1);
      send_request(FUNC_PEAK, 4'd0, 16'd2, 16'd5);
      send_request(FUNC_PEAK, 4'd1, 16'h8000, 16'd5);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      drain();
      write_csr(CFG_RATE, 18'd0);
      write_csr(CFG_CHANS, 18'd0);
      send_request(FUNC_PEAK, 4'd0, 16'h4000, 16'd9);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      drain();
      write_csr(CFG_RATE, 18'h3FFFF);
      write_csr(CFG_CHANS, 18'd31);
      send_request(FUNC_PEAK, 4'd1, 16'h7FFF, 16'hFFFF);
      send_request(FUNC_PEAK, 4'd0, 16'h0001, 16'h0000);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      drain();
      write_csr(CFG_RATE, 18'd1);
      send_request(FUNC_PEAK, 4'd0, 16'd0, 16'd1000);
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);

      // Random phases with different idling on each side.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 49 : 0;
         recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 14 : 0;
         drain();
         write_csr(CFG_RATE, rand_rate());
         write_csr(CFG_GLOBAL, 18'($urandom_range(1)));
         write_csr(CFG_CHANS, 18'($urandom_range(31)));
         for (int k = 0; k < 160; k++) begin
            if (k == 80) drain();
            if ($urandom_range(7) == 0)
               send_request(FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
            else if ($urandom_range(9) == 0)
               send_request(FUNC_PEAK, 4'($urandom), rand_peak(), rand_samples());
            else
               send_request(FUNC_PEAK, 4'($urandom_range(NCH - 1)), rand_peak(),
                            rand_samples());
         end
      end
      send_request(FUNC_TICK, 4'd0, 16'd0, 16'd0);
      drain();

      meter_sb.errors += meter_sb.pending.size();
      if (meter_sb.errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
